FILE: design/jssl_pkg.sv
// Shared types and constants for the joint setpoint slew limiter.
// No dependencies; every other design file refers to this package by scoped names.
package jssl_pkg;

    localparam int NUM_JOINTS    = 8;
    localparam int POS_FRAC_BITS = 12;
    localparam int ANGLE_W       = 16;
    localparam int DIFF_W        = ANGLE_W + 1;
    localparam int STEP_W        = 12;
    localparam int TIMEOUT_W     = 16;
    localparam int IDLE_W        = 17;
    localparam int CMD_W         = 2;
    localparam int MAGIC_W       = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_DATA_W     = MAGIC_W + NUM_JOINTS * ANGLE_W + NUM_JOINTS;
    localparam int OUT_DATA_W    = NUM_JOINTS * ANGLE_W;

    // 0.012 rad rounded to the nearest LSB
    localparam int STEP_RESET_I  = (12 * (1 << POS_FRAC_BITS) + 500) / 1000;
    localparam logic [STEP_W-1:0]    STEP_RESET    = STEP_W'(STEP_RESET_I);
    // 0.35 s at 250 Hz, truncated
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'((350 * 250) / 1000);
    localparam logic [IDLE_W-1:0]    IDLE_MAX      = {IDLE_W{1'b1}};
    localparam logic [MAGIC_W-1:0]   PKT_HEADER    = 32'h4831_4152;

    localparam logic [CMD_W-1:0] CMD_PACKET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEED   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 1'd1;

    typedef logic signed [ANGLE_W-1:0] angle_t;

    // Common control for all lanes for one accepted beat
    typedef struct packed {
        logic              seed;
        logic              tick;
        logic              expired;
        logic [STEP_W-1:0] step_lim;
    } lane_ctrl_t;

    // Output buffer status toward the top level
    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } merge_stat_t;

endpackage

FILE: design/jssl_lane.sv
// One joint lane: goal and output angle registers and the clamped step.
// Depends on jssl_pkg.
module jssl_lane
(
    input  logic                clk,
    input  logic                rst_n,
    input  jssl_pkg::lane_ctrl_t ctrl,
    input  logic                load_goal,
    input  jssl_pkg::angle_t    target,
    output jssl_pkg::angle_t    sent
);

    jssl_pkg::angle_t goal_reg, goal_next;
    jssl_pkg::angle_t out_reg, out_next;
    jssl_pkg::angle_t goal_eff;
    jssl_pkg::angle_t stepped;
    logic signed [jssl_pkg::DIFF_W-1:0] diff, lim_p, lim_n, step;

    always_comb
    begin
        // watchdog pins the goal to the current output
        goal_eff = ctrl.expired ? out_reg : goal_reg;
        diff  = {goal_eff[jssl_pkg::ANGLE_W-1], goal_eff}
              - {out_reg[jssl_pkg::ANGLE_W-1], out_reg};
        lim_p = {{(jssl_pkg::DIFF_W - jssl_pkg::STEP_W){1'b0}}, ctrl.step_lim};
        lim_n = -lim_p;
        if (diff > lim_p)
        begin
            step = lim_p;
        end
        else if (diff < lim_n)
        begin
            step = lim_n;
        end
        else
        begin
            step = diff;
        end
        stepped = out_reg + step[jssl_pkg::ANGLE_W-1:0];
    end

    always_comb
    begin
        goal_next = goal_reg;
        out_next  = out_reg;
        if (ctrl.seed)
        begin
            goal_next = target;
            out_next  = target;
        end
        else if (ctrl.tick)
        begin
            goal_next = goal_eff;
            out_next  = stepped;
        end
        else if (load_goal)
        begin
            goal_next = target;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg <= '0;
            out_reg  <= '0;
        end
        else
        begin
            goal_reg <= goal_next;
            out_reg  <= out_next;
        end
    end

    assign sent = stepped;

endmodule

FILE: design/jssl_merge.sv
// Merge stage: packs the eight lane results and the watchdog flag into one
// beat, held in an output register backed by a skid register. Depends on jssl_pkg.
module jssl_merge
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  produce,
    input  logic [jssl_pkg::OUT_DATA_W-1:0]       lane_data,
    input  logic                                  expired,
    output jssl_pkg::merge_stat_t                 stat,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [jssl_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic [0:0]                            m_tuser
);

    logic                              main_valid_reg, main_valid_next;
    logic                              skid_valid_reg, skid_valid_next;
    logic [jssl_pkg::OUT_DATA_W-1:0]   main_data_reg, main_data_next;
    logic [jssl_pkg::OUT_DATA_W-1:0]   skid_data_reg, skid_data_next;
    logic                              main_flag_reg, main_flag_next;
    logic                              skid_flag_reg, skid_flag_next;
    logic                              main_free;

    always_comb
    begin
        main_free       = !main_valid_reg || m_tready;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        main_flag_next  = main_flag_reg;
        skid_data_next  = skid_data_reg;
        skid_flag_next  = skid_flag_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                // input is stalled while the skid holds a beat
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                main_flag_next  = skid_flag_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = produce;
                main_data_next  = lane_data;
                main_flag_next  = expired;
            end
        end
        else if (produce)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = lane_data;
            skid_flag_next  = expired;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        main_flag_reg <= main_flag_next;
        skid_data_reg <= skid_data_next;
        skid_flag_reg <= skid_flag_next;
    end

    assign stat.main_valid = main_valid_reg;
    assign stat.skid_valid = skid_valid_reg;
    assign m_tvalid   = main_valid_reg;
    assign m_tdata    = main_data_reg;
    assign m_tuser[0] = main_flag_reg;

endmodule

FILE: design/joint_setpoint_slew_limiter_top.sv
// Channel   Dir  Beat contents (low bits first)
// s_*       in   tuser: cmd; tdata: magic, target_0..7, target_valid
// m_*       out  tuser: timed_out; tdata: sent_0..7
// cfg_*     in   index 0 step limit, index 1 timeout ticks, one write per cycle
//
// One beat per cycle while s_tready is high: all eight lanes step in the cycle a tick is accepted,
// and lane and watchdog state is final at that edge, so the next beat follows directly.
// A tick result is registered into the m_* output register when that is free; a skid register
// absorbs one result while m_tready is low, then s_tready drops.
// Reset clears angles to zero and saturates the idle count (watchdog expired).
// Top level: watchdog, config registers, eight lanes and merge stage.
// Depends on jssl_pkg, jssl_lane, jssl_merge.
module joint_setpoint_slew_limiter_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // magic, target_0 .. target_7, target_valid
    input  logic [jssl_pkg::IN_DATA_W-1:0]      s_tdata,
    // cmd
    input  logic [jssl_pkg::CMD_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sent_0 .. sent_7
    output logic [jssl_pkg::OUT_DATA_W-1:0]     m_tdata,
    // timed_out
    output logic [0:0]                          m_tuser,
    input  logic                                cfg_we,
    input  logic [jssl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jssl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int VALID_LSB = jssl_pkg::MAGIC_W + jssl_pkg::NUM_JOINTS * jssl_pkg::ANGLE_W;

    logic [jssl_pkg::STEP_W-1:0]    step_lim_reg, step_lim_next;
    logic [jssl_pkg::TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic [jssl_pkg::IDLE_W-1:0]    idle_count_reg, idle_count_next;

    logic                           accept, pkt_ok, is_tick, is_seed, expired;
    logic [jssl_pkg::MAGIC_W-1:0]   magic;
    logic [jssl_pkg::NUM_JOINTS-1:0] tgt_valid;
    jssl_pkg::lane_ctrl_t           ctrl;
    jssl_pkg::merge_stat_t          stat;
    logic [jssl_pkg::OUT_DATA_W-1:0] lane_data;

    assign s_tready  = !stat.skid_valid;
    assign accept    = s_tvalid && s_tready;
    assign magic     = s_tdata[jssl_pkg::MAGIC_W-1:0];
    assign tgt_valid = s_tdata[VALID_LSB +: jssl_pkg::NUM_JOINTS];
    assign pkt_ok    = accept && (s_tuser == jssl_pkg::CMD_PACKET)
                     && (magic == jssl_pkg::PKT_HEADER);
    assign is_tick   = accept && (s_tuser == jssl_pkg::CMD_TICK);
    assign is_seed   = accept && (s_tuser == jssl_pkg::CMD_SEED);
    assign expired   = idle_count_reg > {1'b0, timeout_reg};

    assign ctrl.seed     = is_seed;
    assign ctrl.tick     = is_tick;
    assign ctrl.expired  = is_tick && expired;
    assign ctrl.step_lim = step_lim_reg;

    always_comb
    begin
        idle_count_next = idle_count_reg;
        if (pkt_ok)
        begin
            idle_count_next = '0;
        end
        else if (is_tick && (idle_count_reg != jssl_pkg::IDLE_MAX))
        begin
            idle_count_next = idle_count_reg + 1'b1;
        end
    end

    always_comb
    begin
        step_lim_next = step_lim_reg;
        timeout_next  = timeout_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                jssl_pkg::REG_STEP_LIM: step_lim_next = cfg_data[jssl_pkg::STEP_W-1:0];
                jssl_pkg::REG_TIMEOUT:  timeout_next  = cfg_data[jssl_pkg::TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_lim_reg   <= jssl_pkg::STEP_RESET;
            timeout_reg    <= jssl_pkg::TIMEOUT_RESET;
            idle_count_reg <= jssl_pkg::IDLE_MAX;
        end
        else
        begin
            step_lim_reg   <= step_lim_next;
            timeout_reg    <= timeout_next;
            idle_count_reg <= idle_count_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < jssl_pkg::NUM_JOINTS; gi++)
        begin : g_lane
            jssl_pkg::angle_t lane_sent;

            jssl_lane u_lane
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .load_goal (pkt_ok && tgt_valid[gi]),
                .target    (s_tdata[jssl_pkg::MAGIC_W + gi*jssl_pkg::ANGLE_W
                                    +: jssl_pkg::ANGLE_W]),
                .sent      (lane_sent)
            );

            assign lane_data[gi*jssl_pkg::ANGLE_W +: jssl_pkg::ANGLE_W] = lane_sent;
        end
    endgenerate

    jssl_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .produce   (is_tick),
        .lane_data (lane_data),
        .expired   (expired),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // a beat in the skid register implies the output register is full
    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        stat.skid_valid |-> stat.main_valid)
        else $error("skid holds a beat while output register is empty");

    // a tick arriving while the output is stalled must land in the skid
    a_tick_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (is_tick && m_tvalid && !m_tready) |=> stat.skid_valid)
        else $error("tick result lost under output stall");

    // a good packet restarts the watchdog
    a_pkt_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_ok |=> (idle_count_reg == '0))
        else $error("idle count not cleared by packet");

    // a tick never lowers the idle count
    a_tick_counts_up: assert property (@(posedge clk) disable iff (!rst_n)
        is_tick |=> (idle_count_reg >= $past(idle_count_reg)))
        else $error("idle count dropped on tick");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking bench for joint_setpoint_slew_limiter_top: random bursts of seed, packet and tick
// beats against a slew and watchdog predictor held in a scoreboard class.
// Depends on jssl_pkg and the design files.
`timescale 1ns / 1ps

module testbench;

    import jssl_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]                     cmd;
        logic [MAGIC_W-1:0]                   magic;
        logic [NUM_JOINTS-1:0][ANGLE_W-1:0]   tgt;
        logic [NUM_JOINTS-1:0]                valid;
    } joint_cmd_t;

    typedef struct packed {
        logic [OUT_DATA_W-1:0] sent;
        logic                  timed_out;
    } setpoint_t;

    class slew_scoreboard;
        angle_t                goal [NUM_JOINTS];
        angle_t                pos [NUM_JOINTS];
        logic [IDLE_W-1:0]     idle_ticks;
        logic [STEP_W-1:0]     step_limit;
        logic [TIMEOUT_W-1:0]  watchdog_limit;
        setpoint_t             expected_q [$];
        int                    errors;

        function new();
            for (int i = 0; i < NUM_JOINTS; i++)
            begin
                goal[i] = '0;
                pos[i]  = '0;
            end
            idle_ticks     = IDLE_MAX;
            step_limit     = STEP_RESET;
            watchdog_limit = TIMEOUT_RESET;
            errors         = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_STEP_LIM)
                step_limit = val[STEP_W-1:0];
            else
                watchdog_limit = val[TIMEOUT_W-1:0];
        endfunction

        function void note_beat(joint_cmd_t b);
            logic      expired;
            int        lim;
            int        d;
            setpoint_t sp;
            case (b.cmd)
                CMD_PACKET:
                begin
                    if (b.magic == PKT_HEADER)
                    begin
                        for (int i = 0; i < NUM_JOINTS; i++)
                            if (b.valid[i])
                                goal[i] = angle_t'(b.tgt[i]);
                        idle_ticks = '0;
                    end
                end
                CMD_SEED:
                begin
                    for (int i = 0; i < NUM_JOINTS; i++)
                    begin
                        goal[i] = angle_t'(b.tgt[i]);
                        pos[i]  = angle_t'(b.tgt[i]);
                    end
                end
                CMD_TICK:
                begin
                    // watchdog compares before the idle count moves
                    expired = idle_ticks > watchdog_limit;
                    lim = int'(step_limit);
                    if (idle_ticks != IDLE_MAX)
                        idle_ticks = idle_ticks + 1'b1;
                    for (int i = 0; i < NUM_JOINTS; i++)
                    begin
                        if (expired)
                            goal[i] = pos[i];
                        d = int'(goal[i]) - int'(pos[i]);
                        if (d > lim)
                            d = lim;
                        if (d < -lim)
                            d = -lim;
                        pos[i] = angle_t'(int'(pos[i]) + d);
                        sp.sent[i*ANGLE_W +: ANGLE_W] = pos[i];
                    end
                    sp.timed_out = expired;
                    expected_q.push_back(sp);
                end
                default: ;
            endcase
        endfunction

        function void flag_mismatch(string what, int exp_val, int act_val);
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %0d, got %0d", what, exp_val, act_val);
        endfunction

        function void check_setpoint(logic [OUT_DATA_W-1:0] data, logic flag);
            setpoint_t sp;
            int        exp_val;
            int        act_val;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result beat with nothing expected: timed_out %0d", flag);
                return;
            end
            sp = expected_q.pop_front();
            for (int i = 0; i < NUM_JOINTS; i++)
            begin
                exp_val = int'(angle_t'(sp.sent[i*ANGLE_W +: ANGLE_W]));
                act_val = int'(angle_t'(data[i*ANGLE_W +: ANGLE_W]));
                if (exp_val != act_val)
                    flag_mismatch($sformatf("sent_%0d", i), exp_val, act_val);
            end
            if (sp.timed_out !== flag)
                flag_mismatch("timed_out", int'(sp.timed_out), int'(flag));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic [CMD_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    slew_scoreboard sb;
    int burst_left = 0;
    int rx_mode = 0;
    int rx_left = 0;
    int rx_period = 2;
    int rx_phase = 0;

    joint_setpoint_slew_limiter_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: switches among always-ready, coin-flip, mostly-stalled and periodic
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode   = $urandom_range(0, 3);
                rx_left   = $urandom_range(20, 200);
                rx_period = $urandom_range(2, 6);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((rx_phase % rx_period) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_setpoint(m_tdata, m_tuser[0]);
    end

    function automatic logic [IN_DATA_W-1:0] pack_beat(joint_cmd_t b);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[MAGIC_W-1:0] = b.magic;
        for (int i = 0; i < NUM_JOINTS; i++)
            d[MAGIC_W + i*ANGLE_W +: ANGLE_W] = b.tgt[i];
        d[MAGIC_W + NUM_JOINTS*ANGLE_W +: NUM_JOINTS] = b.valid;
        return d;
    endfunction

    function automatic logic [ANGLE_W-1:0] rand_angle();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3, 4: return ANGLE_W'($urandom_range(0, 400)) - 16'd200;
            default: return ANGLE_W'($urandom);
        endcase
    endfunction

    function automatic joint_cmd_t mk_beat(logic [CMD_W-1:0] cmd);
        joint_cmd_t b;
        b.cmd   = cmd;
        b.magic = (cmd == CMD_PACKET) ? PKT_HEADER : MAGIC_W'($urandom);
        for (int i = 0; i < NUM_JOINTS; i++)
            b.tgt[i] = rand_angle();
        b.valid = ($urandom_range(0, 9) < 3) ? 8'hFF : NUM_JOINTS'($urandom);
        return b;
    endfunction

    task automatic send_beat(joint_cmd_t b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= pack_beat(b);
        s_tuser  <= b.cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_beat(b);
    endtask

    // stop sending and let every tick result drain before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(logic [CFG_DATA_W-1:0] step, logic [CFG_DATA_W-1:0] tmo);
        cfg_we    <= 1'b1;
        cfg_index <= REG_STEP_LIM;
        cfg_data  <= step;
        @(posedge clk);
        sb.write_reg(REG_STEP_LIM, step);
        cfg_index <= REG_TIMEOUT;
        cfg_data  <= tmo;
        @(posedge clk);
        sb.write_reg(REG_TIMEOUT, tmo);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_directed();
        joint_cmd_t b;
        // watchdog starts expired out of reset
        send_beat(mk_beat(CMD_TICK));
        b = mk_beat(CMD_SEED);
        b.tgt[0] = 16'h7FFF;
        b.tgt[1] = 16'h8000;
        b.tgt[2] = 16'h0000;
        b.tgt[3] = 16'h0001;
        b.tgt[4] = 16'hFFFF;
        b.tgt[5] = 16'h5555;
        b.tgt[6] = 16'hAAAA;
        b.tgt[7] = 16'h0030;
        send_beat(b);
        send_beat(mk_beat(CMD_TICK));
        b = mk_beat(CMD_PACKET);
        b.magic = ~PKT_HEADER;
        b.valid = 8'hFF;
        send_beat(b);
        send_beat(mk_beat(CMD_TICK));
        // full swing, exact-step and equal goals
        b = mk_beat(CMD_PACKET);
        b.valid  = 8'hFF;
        b.tgt[0] = 16'h8000;
        b.tgt[1] = 16'h7FFF;
        b.tgt[2] = 16'h0031;
        b.tgt[3] = 16'hFFCF;
        b.tgt[4] = 16'hFFFF;
        send_beat(b);
        send_beat(mk_beat(CMD_TICK));
        send_beat(mk_beat(CMD_TICK));
        send_beat(mk_beat(CMD_TICK));
        b = mk_beat(CMD_PACKET);
        b.valid = 8'hA5;
        send_beat(b);
        send_beat(mk_beat(CMD_TICK));
        send_beat(mk_beat(CMD_UNUSED));
        send_beat(mk_beat(CMD_TICK));
        b = mk_beat(CMD_PACKET);
        b.valid = 8'h00;
        send_beat(b);
        send_beat(mk_beat(CMD_TICK));
        b = mk_beat(CMD_PACKET);
        b.magic = PKT_HEADER ^ 32'h0000_0001;
        send_beat(b);
        b = mk_beat(CMD_PACKET);
        b.magic = PKT_HEADER ^ 32'h8000_0000;
        send_beat(b);
        send_beat(mk_beat(CMD_TICK));
        send_beat(mk_beat(CMD_SEED));
        send_beat(mk_beat(CMD_TICK));
    endtask

    task automatic run_random(int n);
        int done;
        int r;
        int ticks;
        joint_cmd_t b;
        done = 0;
        while (done < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                send_beat(mk_beat(CMD_SEED));
                done++;
            end
            else if (r < 16)
            begin
                // ignored beats: unused code or a bad header word
                b = mk_beat($urandom_range(0, 1) ? CMD_UNUSED : CMD_PACKET);
                if (b.cmd == CMD_PACKET)
                begin
                    b.magic = $urandom_range(0, 1) ? MAGIC_W'($urandom)
                                                   : PKT_HEADER ^ (32'h1 << $urandom_range(0, 31));
                    if (b.magic == PKT_HEADER)
                        b.magic = b.magic ^ 32'h1;
                end
                send_beat(b);
            end
            else
            begin
                if (r < 85)
                begin
                    send_beat(mk_beat(CMD_PACKET));
                    done++;
                end
                ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 10);
                repeat (ticks)
                begin
                    send_beat(mk_beat(CMD_TICK));
                    done++;
                end
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(300);
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0: write_config(16'd0, 16'd0);
                1: write_config(16'd4095, 16'hFFFF);
                2: write_config(16'd4095, 16'd0);
                3: write_config(16'd1, 16'd3);
                4: write_config(CFG_DATA_W'($urandom), 16'd20);
                default: write_config(CFG_DATA_W'($urandom_range(0, 4095)),
                                      CFG_DATA_W'($urandom_range(0, 12)));
            endcase
            run_random(270);
        end
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end

endmodule

FILE: sim.f
design/jssl_pkg.sv
design/jssl_lane.sv
design/jssl_merge.sv
design/joint_setpoint_slew_limiter_top.sv
tb/sv/testbench.sv
